// ===== sv/pic16ie_pkg.sv =====
`default_nettype none
package pic16ie_pkg;

  localparam int PC_W = 14;

  localparam logic [PC_W-1:0] DEBUG_VECTOR = 14'h2004;
  localparam logic [PC_W-1:0] IRQ_VECTOR   = 14'h0004;

  localparam logic [3:0] WARMUP_RESET = 4'd5;
  localparam logic [3:0] WARMUP_MAX   = 4'd15;
  localparam logic [3:0] WARMUP_MIN   = 4'd3;
  localparam logic [7:0] STEP_MAX     = 8'd255;
  localparam logic [7:0] STEP_HALT    = 8'd3;

  localparam int GIE_BIT    = 7;
  localparam int PEIE_BIT   = 6;
  localparam int HALT_BIT   = 7;
  localparam int SSTEP_BIT  = 5;

  localparam logic [7:0] PIR1_MASK = 8'h7F;
  localparam logic [1:0] PIR2_MASK = 2'h3;

  typedef struct packed {
    logic [PC_W-1:0] program_counter;
    logic [7:0]      intcon_value;
    logic [7:0]      pie1_value;
    logic [7:0]      pir1_value;
    logic [7:0]      pie2_value;
    logic [7:0]      pir2_value;
    logic            has_second_bank;
    logic            instruction_pending;
    logic            clock_pin_level;
    logic [7:0]      debug_control;
    logic [7:0]      breakpoint_low;
  } req_t;

  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            took_interrupt;
    logic            took_debug_halt;
    logic [7:0]      intcon_out;
    logic [7:0]      debug_control_out;
    logic [7:0]      breakpoint_low_out;
    logic            instruction_pending_out;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/pic16ie_stack_cell.sv =====
`default_nettype none
module pic16ie_stack_cell
  import pic16ie_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [PC_W-1:0] d,
  output logic      [PC_W-1:0] q
);

  logic [PC_W-1:0] entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (push) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule
`default_nettype wire

// ===== sv/pic16ie_entry.sv =====
`default_nettype none
module pic16ie_entry
  import pic16ie_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire logic debug_enable,
  input  wire req_t req,
  output rsp_t      result,
  output logic      push
);

  logic       clock_pin_prev;
  logic [3:0] warmup_count;
  logic [7:0] single_step_count;

  logic [3:0]      warmup_next;
  logic [7:0]      step_next;
  logic            dbg_active;
  logic            pin_fall;
  logic            brk;
  logic            step_halt;
  logic            halt;
  logic            irq_req;
  logic            irq;
  logic [PC_W-1:0] bp_plus_one;
  logic [7:0]      intcon;

  assign intcon = req.intcon_value;

  always_comb begin
    dbg_active  = debug_enable & ~req.debug_control[HALT_BIT];
    warmup_next = (warmup_count == WARMUP_MAX) ? warmup_count : warmup_count + 4'd1;
    step_next   = (single_step_count == STEP_MAX) ? single_step_count
                                                  : single_step_count + 8'd1;
    pin_fall    = clock_pin_prev & ~req.clock_pin_level;
    bp_plus_one = {1'b0, req.debug_control[4:0], req.breakpoint_low} + 14'd1;
    brk         = (req.program_counter == bp_plus_one) && (warmup_next > WARMUP_MIN);
    step_halt   = req.debug_control[SSTEP_BIT] && (step_next == STEP_HALT);
    halt        = dbg_active & (pin_fall | brk | step_halt);

    irq_req = intcon[GIE_BIT] &&
              ((|(intcon[5:3] & intcon[2:0])) ||
               (intcon[PEIE_BIT] &&
                ((|(req.pie1_value & req.pir1_value & PIR1_MASK)) ||
                 (req.has_second_bank &&
                  (|(req.pie2_value[1:0] & req.pir2_value[1:0] & PIR2_MASK))))));
    irq     = ~halt & ~req.instruction_pending & irq_req;
    push    = halt | irq;
  end

  always_comb begin
    result.next_pc                 = req.program_counter;
    result.took_interrupt          = irq;
    result.took_debug_halt         = halt;
    result.intcon_out              = intcon;
    result.debug_control_out       = req.debug_control;
    result.breakpoint_low_out      = req.breakpoint_low;
    result.instruction_pending_out = req.instruction_pending | halt | irq;
    if (halt) begin
      result.next_pc            = DEBUG_VECTOR;
      result.debug_control_out  = {1'b1, req.debug_control[6:5], req.program_counter[12:8]};
      result.breakpoint_low_out = req.program_counter[7:0];
    end else if (irq) begin
      result.next_pc                 = IRQ_VECTOR;
      result.intcon_out[GIE_BIT]     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_pin_prev    <= 1'b0;
      warmup_count      <= WARMUP_RESET;
      single_step_count <= '0;
    end else if (accept && debug_enable) begin
      clock_pin_prev <= req.clock_pin_level;
      if (dbg_active) begin
        warmup_count <= warmup_next;
        if (req.debug_control[SSTEP_BIT]) begin
          single_step_count <= step_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/pic16_interrupt_and_debug_entry.sv =====
// PIC16 interrupt and debug entry. Takes one item per executed instruction
// step and returns one result item per step: the debug halt check (clock pin
// falling edge, breakpoint match after warm-up, third single step) and the
// interrupt check are made in the cycle the item is accepted, and the result
// goes to rsp (to skid if rsp stalls). A new item can be accepted every
// cycle; throughput is one item per cycle while rsp is not stalled. An output
// register plus one skid register sit on the result side, so req_stall rises
// only once both hold unaccepted results. Every entry pushes the pc onto a
// return stack built as a row of STACK_DEPTH cells that shift together.
// debug_enable is written through the cfg channel, which is always ready.
`default_nettype none
module pic16_interrupt_and_debug_entry
  import pic16ie_pkg::*;
#(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  logic debug_enable;
  logic skid_valid;
  rsp_t skid;
  rsp_t result;
  logic push;
  logic accept;
  logic rsp_free;

  logic [PC_W-1:0] stack [STACK_DEPTH];

  assign cfg_ready = 1'b1;
  assign req_stall = skid_valid;
  assign accept    = req_valid & ~req_stall;
  assign rsp_free  = ~rsp_valid | ~rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debug_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      debug_enable <= cfg_data;
    end
  end

  pic16ie_entry u_entry (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .debug_enable (debug_enable),
    .req          (req),
    .result       (result),
    .push         (push)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stack
    pic16ie_stack_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .push (accept & push),
      .d    ((i == 0) ? req.program_counter : stack[(i == 0) ? 0 : i - 1]),
      .q    (stack[i])
    );
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid  <= skid_valid | accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_free) begin
      rsp <= skid_valid ? skid : result;
    end else if (accept) begin
      skid <= result;
    end
  end

  a_one_entry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.took_interrupt && rsp.took_debug_halt))
    else $error("interrupt and debug halt in the same item");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid holds an item while output register is empty");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    (accept && push) |=> stack[0] == $past(req.program_counter))
    else $error("stack top does not hold the pushed pc");

  a_push_deep: assert property (@(posedge clk) disable iff (rst)
    (accept && push) |=> stack[STACK_DEPTH-1] == $past(stack[STACK_DEPTH-2]))
    else $error("stack did not shift down on push");

  a_entry_pending: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.took_interrupt || rsp.took_debug_halt)) |->
      rsp.instruction_pending_out)
    else $error("entry without pending flag");

endmodule
`default_nettype wire

// ===== tb/pic16ie_entry_checker.sv =====
module pic16ie_entry_checker
  import pic16ie_pkg::*;
#(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_stall,
  input  wire req_t req,
  input  wire logic rsp_valid,
  input  wire logic rsp_stall,
  input  wire rsp_t rsp,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic cfg_data,
  output int        mismatches,
  output int        outstanding
);

  rsp_t            expected_steps[$];
  logic [PC_W-1:0] return_stack[STACK_DEPTH];
  logic            pin_prev;
  logic [3:0]      warmup;
  logic [7:0]      step_count;
  logic            dbg_en;

  function automatic void push_return(logic [PC_W-1:0] pc);
    for (int i = STACK_DEPTH - 1; i > 0; i--) return_stack[i] = return_stack[i-1];
    return_stack[0] = pc;
  endfunction

  // one instruction step: debug halt first, then interrupt entry
  function automatic rsp_t enter_step(req_t r);
    rsp_t            o;
    logic [PC_W-1:0] pc;
    logic [7:0]      dc;
    logic [7:0]      bl;
    logic            pend;
    logic            prev;
    logic            stepping;
    logic            hit_edge;
    logic            hit_brk;
    logic            hit_step;
    logic            irq;
    pc   = r.program_counter;
    dc   = r.debug_control;
    bl   = r.breakpoint_low;
    pend = r.instruction_pending;
    o.next_pc         = pc;
    o.took_interrupt  = 1'b0;
    o.took_debug_halt = 1'b0;
    o.intcon_out      = r.intcon_value;
    if (dbg_en) begin
      prev     = pin_prev;
      pin_prev = r.clock_pin_level;
      if (!dc[HALT_BIT]) begin
        stepping = dc[SSTEP_BIT];
        if (warmup != WARMUP_MAX) warmup = warmup + 4'd1;
        if (stepping && step_count != STEP_MAX) step_count = step_count + 8'd1;
        hit_edge = prev && !r.clock_pin_level;
        hit_brk  = (pc == ({1'b0, dc[4:0], bl} + 14'd1)) && (warmup > WARMUP_MIN);
        hit_step = stepping && (step_count == STEP_HALT);
        if (hit_edge || hit_brk || hit_step) begin
          push_return(pc);
          dc = {1'b1, dc[6:5], pc[12:8]};
          bl = pc[7:0];
          o.next_pc = DEBUG_VECTOR;
          pend = 1'b1;
          o.took_debug_halt = 1'b1;
        end
      end
    end
    irq = r.intcon_value[GIE_BIT] &&
          (|(r.intcon_value[5:3] & r.intcon_value[2:0]) ||
           (r.intcon_value[PEIE_BIT] &&
            (|(r.pie1_value & r.pir1_value & PIR1_MASK) ||
             (r.has_second_bank && |(r.pie2_value[1:0] & r.pir2_value[1:0] & PIR2_MASK)))));
    if (!pend && irq) begin
      o.intcon_out[GIE_BIT] = 1'b0;
      push_return(pc);
      o.next_pc = IRQ_VECTOR;
      pend = 1'b1;
      o.took_interrupt = 1'b1;
    end
    o.debug_control_out       = dc;
    o.breakpoint_low_out      = bl;
    o.instruction_pending_out = pend;
    return o;
  endfunction

  task automatic compare_field(string fname, int expv, int actv);
    if (expv != actv) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", fname, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      expected_steps.delete();
      foreach (return_stack[i]) return_stack[i] = '0;
      pin_prev   = 1'b0;
      warmup     = WARMUP_RESET;
      step_count = '0;
      dbg_en     = 1'b0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) dbg_en = cfg_data;
      if (req_valid && !req_stall) expected_steps.push_back(enter_step(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_steps.size() == 0) begin
          if (mismatches < 10) $display("result item with nothing expected: %h", rsp);
          mismatches++;
        end else begin
          want = expected_steps.pop_front();
          compare_field("next_pc", want.next_pc, rsp.next_pc);
          compare_field("took_interrupt", want.took_interrupt, rsp.took_interrupt);
          compare_field("took_debug_halt", want.took_debug_halt, rsp.took_debug_halt);
          compare_field("intcon_out", want.intcon_out, rsp.intcon_out);
          compare_field("debug_control_out", want.debug_control_out, rsp.debug_control_out);
          compare_field("breakpoint_low_out", want.breakpoint_low_out,
                        rsp.breakpoint_low_out);
          compare_field("instruction_pending_out", want.instruction_pending_out,
                        rsp.instruction_pending_out);
        end
      end
      outstanding <= expected_steps.size();
    end
  end

endmodule

// ===== tb/pic16_interrupt_and_debug_entry_test.sv =====
module pic16_interrupt_and_debug_entry_test;
  import pic16ie_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_rsp = 1'b0;

  always #5 clk = ~clk;

  pic16_interrupt_and_debug_entry dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pic16ie_entry_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic req_t step_item(logic [PC_W-1:0] pc, logic [7:0] intcon,
                                     logic [7:0] pie1, logic [7:0] pir1,
                                     logic [7:0] pie2, logic [7:0] pir2, logic bank2,
                                     logic pend, logic pin, logic [7:0] dctl,
                                     logic [7:0] blow);
    req_t r;
    r.program_counter     = pc;
    r.intcon_value        = intcon;
    r.pie1_value          = pie1;
    r.pir1_value          = pir1;
    r.pie2_value          = pie2;
    r.pir2_value          = pir2;
    r.has_second_bank     = bank2;
    r.instruction_pending = pend;
    r.clock_pin_level     = pin;
    r.debug_control       = dctl;
    r.breakpoint_low      = blow;
    return r;
  endfunction

  function automatic req_t rand_step();
    req_t r;
    r.intcon_value            = 8'($urandom);
    r.intcon_value[GIE_BIT]   = ($urandom_range(0, 3) != 0);
    r.intcon_value[PEIE_BIT]  = ($urandom_range(0, 3) != 0);
    r.pie1_value              = 8'($urandom);
    r.pir1_value              = 8'($urandom);
    r.pie2_value              = 8'($urandom);
    r.pir2_value              = 8'($urandom);
    r.has_second_bank         = 1'($urandom);
    r.instruction_pending     = ($urandom_range(0, 3) == 0);
    r.clock_pin_level         = 1'($urandom);
    r.debug_control           = 8'($urandom);
    r.debug_control[HALT_BIT] = ($urandom_range(0, 3) == 0);
    r.breakpoint_low          = 8'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        r.program_counter = {1'b0, r.debug_control[4:0], r.breakpoint_low} + 14'd1;
      end
      1: begin
        r.program_counter = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        r.program_counter = PC_W'($urandom);
      end
    endcase
    return r;
  endfunction

  task automatic send_step(req_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_debug(logic value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stall per item, one long hold-off on request
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      w = rx_idle ? $urandom_range(0, 14) : 0;
      if (w > 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // interrupt sources with debug off
    send_step(step_item(14'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h3FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1, 8'hFF, 8'hFF));
    send_step(step_item(14'h0123, 8'hA4, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h3FFF, 8'h92, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0456, 8'h89, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0010, 8'hC0, 8'h80, 8'h80, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0011, 8'hC0, 8'h01, 8'h01, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0012, 8'hC0, 8'h7F, 8'h00, 8'h03, 8'h03, 1, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0013, 8'hC0, 8'h7F, 8'h00, 8'h03, 8'h03, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0014, 8'hC0, 8'h00, 8'h00, 8'hFC, 8'hFC, 1, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0015, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0016, 8'hA4, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0, 8'h00, 8'h00));

    // debug entries: pin edge, halted, breakpoints, single step
    set_debug(1'b1);
    send_step(step_item(14'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 1, 8'h00, 8'h00));
    send_step(step_item(14'h0101, 8'hA4, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    send_step(step_item(14'h0102, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 1, 8'h80, 8'h00));
    send_step(step_item(14'h0103, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h80, 8'h00));
    send_step(step_item(14'h2000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h1F, 8'hFF));
    send_step(step_item(14'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00));
    repeat (3)
      send_step(step_item(14'h0300, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h20, 8'h10));
    send_step(step_item(14'h0005, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0, 8'h00, 8'h04));
    send_step(step_item(14'h2000, 8'hA4, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h5F, 8'hFF));
    send_step(step_item(14'h3FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1, 8'hFF, 8'hFF));

    // back-to-back items against a long result hold-off
    hold_rsp = 1'b1;
    tx_idle  = 1'b0;
    repeat (30) send_step(rand_step());
    tx_idle = 1'b1;
    repeat (170) send_step(rand_step());

    set_debug(1'b0);
    repeat (50) send_step(rand_step());
    wait_drained();
    repeat (50) send_step(rand_step());

    set_debug(1'b1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (60) send_step(rand_step());
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (140) send_step(rand_step());

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pic16ie_pkg.sv
sv/pic16ie_stack_cell.sv
sv/pic16ie_entry.sv
sv/pic16_interrupt_and_debug_entry.sv
tb/pic16ie_entry_checker.sv
tb/pic16_interrupt_and_debug_entry_test.sv
